[rtl/team_queue_assert.svh]
// assertion macros shared by the team queue rtl
`ifndef TEAM_QUEUE_ASSERT_SVH
`define TEAM_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tq_pkg.sv]
// constants, codes and types of the team queue
package tq_pkg;

   localparam int NUM_GROUPS = 16;
   localparam int CAPACITY   = 1024;
   localparam int ID_BITS    = 16;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int GRP_W   = $clog2(NUM_GROUPS);
   localparam int OCNT_W  = $clog2(NUM_GROUPS + 1);

   localparam int MEMBER_W = 16;
   localparam int GROUP_W  = 4;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic {
      ACT_ENQ = 1'b0,
      ACT_DEQ = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

[rtl/tq_ram.sv]
// generic single-write, single-read ram with registered read
module tq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/team_queue.sv]
// team queue top level: grouped fifo over shared linked-list entry memories
//
// A request word either enqueues a member behind the last waiting member of its
// group (or at the tail when the group has nobody waiting) or dequeues the member
// at the front. Each accepted word yields exactly one response word carrying a
// status (ok, dequeue while empty, enqueue while full) and the removed member id.
// In the accept cycle the block issues one read to the member ram and one to the
// link ram (the released-entry link for an enqueue, the front entry for a
// dequeue); in the execute state the registered read data is used and all writes
// and pointer updates happen at once. No new word is taken until that
// read-then-write pass is done. The execute state waits only when the previous
// response word is still held in the output register and not taken.
// A new request is taken while a finished response waits downstream. No clearing
// pass follows reset: entries are only read after they were written.
`include "team_queue_assert.svh"

module team_queue (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [0] action, [16:1] member_id, [20:17] group_id, [23:21] zero
   input  logic [tq_pkg::REQ_DATA_W-1:0] req_tdata,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [1:0] status, [17:2] out_member, [23:18] zero
   output logic [tq_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW  = tq_pkg::ADDR_W;
   localparam int CW  = tq_pkg::CNT_W;
   localparam int GW  = tq_pkg::GRP_W;
   localparam int OCW = tq_pkg::OCNT_W;
   localparam int IW  = tq_pkg::ID_BITS;

   // control state
   tq_pkg::state_type        state_ff, state_in;
   logic [AW-1:0]            free_top_ff, free_top_in;
   logic [CW-1:0]            fresh_used_ff, fresh_used_in;
   logic [CW-1:0]            total_count_ff, total_count_in;
   logic [GW-1:0]            order_read_ff, order_read_in;
   logic [GW-1:0]            order_write_ff, order_write_in;
   logic [OCW-1:0]           order_count_ff, order_count_in;
   logic [tq_pkg::NUM_GROUPS-1:0] waiting_ff, waiting_in;

   // group tables, undefined until written
   logic [AW-1:0]            group_first_ff [tq_pkg::NUM_GROUPS];
   logic [AW-1:0]            group_last_ff  [tq_pkg::NUM_GROUPS];
   logic [GW-1:0]            order_ring_ff  [tq_pkg::NUM_GROUPS];

   // captured request word
   tq_pkg::action_type       act_ff;
   logic [IW-1:0]            member_ff;
   logic [GW-1:0]            group_ff;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   tq_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [tq_pkg::MEMBER_W-1:0] rsp_member_ff, rsp_member_in;

   // ram ports
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr;
   logic [IW-1:0]            mem_rd_data;
   logic                     link_wr_en;
   logic [AW-1:0]            link_wr_addr;
   logic [AW-1:0]            link_wr_data;
   logic [AW-1:0]            link_rd_data;
   logic [AW-1:0]            rd_addr;

   // datapath decode
   logic                     req_fire;
   logic                     exec_fire;
   tq_pkg::action_type       req_act;
   logic                     reuse_entry;
   logic                     is_full;
   logic                     is_empty;
   logic [GW-1:0]            deq_group;
   logic [AW-1:0]            deq_entry;
   logic [GW-1:0]            cur_group;
   logic [AW-1:0]            cur_last;
   logic [AW-1:0]            new_entry;
   logic                     enq_ok;
   logic                     deq_ok;
   logic                     deq_drains_group;

   assign req_tready = (state_ff == tq_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // finish only when the output register can take the response
   assign exec_fire  = (state_ff == tq_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign req_act    = tq_pkg::action_type'(req_tdata[0]);

   // state does not move between accept and execute, so both cycles share this decode
   assign reuse_entry = fresh_used_ff > total_count_ff;
   assign is_full     = total_count_ff == CW'(tq_pkg::CAPACITY);
   assign is_empty    = (total_count_ff == '0) || (order_count_ff == '0);
   assign deq_group   = order_ring_ff[order_read_ff];
   assign deq_entry   = group_first_ff[deq_group];
   assign new_entry   = reuse_entry ? free_top_ff : fresh_used_ff[AW-1:0];
   assign cur_group   = (act_ff == tq_pkg::ACT_DEQ) ? deq_group : group_ff;
   assign cur_last    = group_last_ff[cur_group];

   assign enq_ok = exec_fire && (act_ff == tq_pkg::ACT_ENQ) && !is_full;
   assign deq_ok = exec_fire && (act_ff == tq_pkg::ACT_DEQ) && !is_empty;
   assign deq_drains_group = deq_entry == cur_last;

   // one read per ram in the accept cycle
   assign rd_addr = (req_act == tq_pkg::ACT_DEQ) ? deq_entry : free_top_ff;

   // member store: written on enqueue, read at the front entry on dequeue
   assign mem_wr_en   = enq_ok;
   assign mem_wr_addr = new_entry;

   // link store: chain behind the group tail, or push the freed entry
   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = new_entry;
      link_wr_data = new_entry;
      if (enq_ok && waiting_ff[group_ff]) begin
         link_wr_en   = 1'b1;
         link_wr_addr = cur_last;
         link_wr_data = new_entry;
      end else if (deq_ok) begin
         link_wr_en   = 1'b1;
         link_wr_addr = deq_entry;
         link_wr_data = free_top_ff;
      end
   end

   tq_ram #(
      .WIDTH (IW),
      .DEPTH (tq_pkg::CAPACITY)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (member_ff),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data)
   );

   tq_ram #(
      .WIDTH (AW),
      .DEPTH (tq_pkg::CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (link_rd_data)
   );

   // next-state for the control registers
   always_comb begin
      state_in       = state_ff;
      free_top_in    = free_top_ff;
      fresh_used_in  = fresh_used_ff;
      total_count_in = total_count_ff;
      order_read_in  = order_read_ff;
      order_write_in = order_write_ff;
      order_count_in = order_count_ff;
      waiting_in     = waiting_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_member_in  = rsp_member_ff;

      unique case (state_ff)
         tq_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = tq_pkg::ST_EXEC;
            end
         end
         tq_pkg::ST_EXEC: begin
            if (exec_fire) begin
               state_in      = tq_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = tq_pkg::STAT_OK;
               rsp_member_in = '0;
               if (act_ff == tq_pkg::ACT_ENQ) begin
                  if (is_full) begin
                     rsp_status_in = tq_pkg::STAT_FULL;
                  end else begin
                     // allocation: released entry first, else the next fresh one
                     if (reuse_entry) begin
                        free_top_in = link_rd_data;
                     end else begin
                        fresh_used_in = fresh_used_ff + CW'(1);
                     end
                     if (!waiting_ff[group_ff]) begin
                        waiting_in[group_ff] = 1'b1;
                        order_write_in = order_write_ff + GW'(1);
                        order_count_in = order_count_ff + OCW'(1);
                     end
                     total_count_in = total_count_ff + CW'(1);
                  end
               end else begin
                  if (is_empty) begin
                     rsp_status_in = tq_pkg::STAT_EMPTY;
                  end else begin
                     rsp_member_in = tq_pkg::MEMBER_W'(mem_rd_data);
                     if (deq_drains_group) begin
                        waiting_in[deq_group] = 1'b0;
                        order_read_in  = order_read_ff + GW'(1);
                        order_count_in = order_count_ff - OCW'(1);
                     end
                     free_top_in    = deq_entry;
                     total_count_in = total_count_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = tq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tq_pkg::ST_IDLE;
         free_top_ff    <= '0;
         fresh_used_ff  <= '0;
         total_count_ff <= '0;
         order_read_ff  <= '0;
         order_write_ff <= '0;
         order_count_ff <= '0;
         waiting_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_top_ff    <= free_top_in;
         fresh_used_ff  <= fresh_used_in;
         total_count_ff <= total_count_in;
         order_read_ff  <= order_read_in;
         order_write_ff <= order_write_in;
         order_count_ff <= order_count_in;
         waiting_ff     <= waiting_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload: captured request, response word, group tables
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_member_ff <= rsp_member_in;
      if (req_fire) begin
         act_ff    <= req_act;
         member_ff <= IW'(req_tdata[16:1]);
         group_ff  <= GW'(req_tdata[20:17] % tq_pkg::NUM_GROUPS);
      end
      if (enq_ok) begin
         group_last_ff[group_ff] <= new_entry;
         if (!waiting_ff[group_ff]) begin
            group_first_ff[group_ff]      <= new_entry;
            order_ring_ff[order_write_ff] <= group_ff;
         end
      end
      if (deq_ok && !deq_drains_group) begin
         group_first_ff[deq_group] <= link_rd_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tq_pkg::RSP_DATA_W - tq_pkg::STATUS_W - tq_pkg::MEMBER_W){1'b0}},
                        rsp_member_ff, rsp_status_ff};

   // queue bookkeeping checks
   `TQ_ASSERT_IMPL(a_total_bound, clock, reset, 1'b1, total_count_ff <= fresh_used_ff, "total above entries ever used")
   `TQ_ASSERT_IMPL(a_order_match, clock, reset, 1'b1, $countones(waiting_ff) == int'(order_count_ff), "waiting groups disagree with order count")
   `TQ_ASSERT_IMPL(a_empty_idle, clock, reset, total_count_ff == '0, waiting_ff == '0, "group waiting in an empty queue")
   `TQ_ASSERT_NEXT(a_accept_exec, clock, reset, req_fire, state_ff == tq_pkg::ST_EXEC, "accepted word not executed")
   `TQ_ASSERT_NEXT(a_exec_rsp, clock, reset, exec_fire, rsp_valid_ff, "executed word left no response")

endmodule
